FILE: rtl/nsep_pkg.sv
// ----------------------------------------------------------------------------
// nsep_pkg
// Shared types and constants for the nearest segment endpoint search.
// ----------------------------------------------------------------------------
package nsep_pkg;

   localparam int MAX_SEGMENTS_DEF = 1024;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      RSP_FULL,
      RSP_EMPTY,
      RSP_QUERY
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        seg_id;
      logic signed [15:0] seg_ax;
      logic signed [15:0] seg_ay;
      logic signed [15:0] seg_bx;
      logic signed [15:0] seg_by;
      logic signed [15:0] span_x;
      logic signed [15:0] span_top_y;
      logic signed [15:0] span_bottom_y;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] top_nearest_id;
      logic [16:0] top_distance;
      logic [15:0] bottom_nearest_id;
      logic [16:0] bottom_distance;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic         clear;
      logic         write;
      logic         capture;
      logic         scan_init;
      logic         issue;
      logic         pass2;
      logic         sq_start;
      logic         sq_sel;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic issue_done;
      logic pipe_empty;
      logic sq_done;
   } sts_type;

endpackage

FILE: rtl/nsep_ctrl.sv
// ----------------------------------------------------------------------------
// nsep_ctrl
// Sequencer: decodes words, runs the two table passes and the square roots.
// ----------------------------------------------------------------------------
module nsep_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        action,
   input  nsep_pkg::sts_type sts,
   output nsep_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN1, ST_DRAIN1, ST_SQT, ST_SQB, ST_SCAN2, ST_DRAIN2, ST_RESP
   } state_type;

   state_type              state_ff;
   logic                   busy_ff;
   logic                   rsp_valid_ff;
   nsep_pkg::rsp_kind_type kind_ff;
   logic                   accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.rsp_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.clear     = (action == nsep_pkg::ACT_CLEAR);
               cmd.write     = (action == nsep_pkg::ACT_ADD) && !sts.full;
               cmd.capture   = (action == nsep_pkg::ACT_QUERY);
               cmd.scan_init = (action == nsep_pkg::ACT_QUERY) && !sts.empty;
            end
         end
         ST_SCAN1:  cmd.issue = !sts.issue_done;
         ST_DRAIN1: cmd.sq_start = sts.pipe_empty;
         ST_SQT: begin
            cmd.sq_start = sts.sq_done;
            cmd.sq_sel   = 1'b1;
         end
         ST_SQB: cmd.scan_init = sts.sq_done;
         ST_SCAN2: begin
            cmd.issue = !sts.issue_done;
            cmd.pass2 = 1'b1;
         end
         ST_DRAIN2: cmd.pass2 = 1'b1;
         ST_RESP:   cmd.rsp_load = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= nsep_pkg::RSP_QUERY;
      end else begin
         rsp_valid_ff <= (state_ff == ST_RESP);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (action == nsep_pkg::ACT_ADD && sts.full) begin
                     kind_ff  <= nsep_pkg::RSP_FULL;
                     state_ff <= ST_RESP;
                     busy_ff  <= 1'b1;
                  end else if (action == nsep_pkg::ACT_QUERY) begin
                     busy_ff <= 1'b1;
                     if (sts.empty) begin
                        kind_ff  <= nsep_pkg::RSP_EMPTY;
                        state_ff <= ST_RESP;
                     end else begin
                        kind_ff  <= nsep_pkg::RSP_QUERY;
                        state_ff <= ST_SCAN1;
                     end
                  end
               end
            end
            ST_SCAN1:  if (sts.issue_done) state_ff <= ST_DRAIN1;
            ST_DRAIN1: if (sts.pipe_empty) state_ff <= ST_SQT;
            ST_SQT:    if (sts.sq_done) state_ff <= ST_SQB;
            ST_SQB:    if (sts.sq_done) state_ff <= ST_SCAN2;
            ST_SCAN2:  if (sts.issue_done) state_ff <= ST_DRAIN2;
            ST_DRAIN2: if (sts.pipe_empty) state_ff <= ST_RESP;
            ST_RESP: begin
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/nsep_dp.sv
// ----------------------------------------------------------------------------
// nsep_dp
// Segment table, distance pipeline, running minimum and square root unit.
// ----------------------------------------------------------------------------
module nsep_dp #(
   parameter int MAX_SEGMENTS = nsep_pkg::MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  nsep_pkg::req_type req_data,
   input  nsep_pkg::cmd_type cmd,
   output nsep_pkg::sts_type sts,
   output nsep_pkg::rsp_type rsp_data
);

   localparam int CntW = $clog2(MAX_SEGMENTS + 1);
   localparam int IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_SEGMENTS);

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_RUN,
      SQ_FIN
   } sq_phase_type;

   logic [15:0] ids_mem [MAX_SEGMENTS];
   logic [63:0] cor_mem [MAX_SEGMENTS];

   logic [CntW-1:0] count_ff, addr_ff;
   logic signed [15:0] px_ff, pyt_ff, pyb_ff;

   // stage 0: table read
   logic        v0_ff;
   logic [15:0] id0_ff;
   logic [63:0] cor0_ff;
   // stage 1: squares
   logic        v1_ff;
   logic [15:0] id1_ff;
   logic [31:0] sxa_ff, sxb_ff, syat_ff, sybt_ff, syab_ff, sybb_ff;
   // stage 2: nearest corner per span point
   logic        v2_ff;
   logic [15:0] id2_ff;
   logic [32:0] st_ff, sb_ff;
   // accumulators
   logic        first_ff;
   logic [32:0] min_t_ff, min_b_ff;
   logic        hit_t_ff, hit_b_ff;
   logic [15:0] id_t_ff, id_b_ff;
   // square root unit
   sq_phase_type sq_ph_ff;
   logic        sq_sel_ff;
   logic [4:0]  sq_bit_ff;
   logic [32:0] sq_n_ff;
   logic [16:0] sq_r_ff, r_t_ff, r_b_ff;
   logic [35:0] thr_t_ff, thr_b_ff;
   nsep_pkg::rsp_type rsp_ff, rsp_in;

   function automatic logic [31:0] sq16(input logic signed [15:0] a,
                                        input logic signed [15:0] b);
      logic signed [16:0] d;
      logic signed [33:0] p;
      d = 17'(a) - 17'(b);
      p = d * d;
      return p[31:0];
   endfunction

   function automatic logic [32:0] min4(input logic [32:0] a, input logic [32:0] b,
                                        input logic [32:0] c, input logic [32:0] d);
      logic [32:0] x, y;
      x = (b < a) ? b : a;
      y = (d < c) ? d : c;
      return (y < x) ? y : x;
   endfunction

   logic signed [15:0] ax, ay, bx, by;
   logic [16:0] sq_t;
   logic [33:0] sq_tt;
   logic [17:0] r_inc;
   assign ax    = cor0_ff[15:0];
   assign ay    = cor0_ff[31:16];
   assign bx    = cor0_ff[47:32];
   assign by    = cor0_ff[63:48];
   assign sq_t  = sq_r_ff | (17'd1 << sq_bit_ff);
   assign sq_tt = sq_t * sq_t;
   assign r_inc = {1'b0, sq_r_ff} + 18'd1;

   // table write and read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         ids_mem[count_ff[IdxW-1:0]] <= req_data.seg_id;
         cor_mem[count_ff[IdxW-1:0]] <= {req_data.seg_by, req_data.seg_bx,
                                         req_data.seg_ay, req_data.seg_ax};
      end
      id0_ff  <= ids_mem[addr_ff[IdxW-1:0]];
      cor0_ff <= cor_mem[addr_ff[IdxW-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         addr_ff  <= '0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         sq_ph_ff <= SQ_IDLE;
      end else begin
         if (cmd.clear) count_ff <= '0;
         else if (cmd.write) count_ff <= count_ff + 1'b1;
         if (cmd.scan_init) addr_ff <= '0;
         else if (cmd.issue) addr_ff <= addr_ff + 1'b1;
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         unique case (sq_ph_ff)
            SQ_IDLE: if (cmd.sq_start) sq_ph_ff <= SQ_RUN;
            SQ_RUN:  if (sq_bit_ff == 5'd0) sq_ph_ff <= SQ_FIN;
            SQ_FIN:  sq_ph_ff <= SQ_IDLE;
            default: sq_ph_ff <= SQ_IDLE;
         endcase
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_kind)
         nsep_pkg::RSP_FULL:  rsp_in.table_full = 1'b1;
         nsep_pkg::RSP_EMPTY: rsp_in.found = 1'b0;
         nsep_pkg::RSP_QUERY: begin
            rsp_in.found             = 1'b1;
            rsp_in.top_nearest_id    = id_t_ff;
            rsp_in.top_distance      = r_t_ff;
            rsp_in.bottom_nearest_id = id_b_ff;
            rsp_in.bottom_distance   = r_b_ff;
         end
         default: rsp_in.found = 1'b0;
      endcase
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff  <= req_data.span_x;
         pyt_ff <= req_data.span_top_y;
         pyb_ff <= req_data.span_bottom_y;
      end
      id1_ff  <= id0_ff;
      sxa_ff  <= sq16(ax, px_ff);
      sxb_ff  <= sq16(bx, px_ff);
      syat_ff <= sq16(ay, pyt_ff);
      sybt_ff <= sq16(by, pyt_ff);
      syab_ff <= sq16(ay, pyb_ff);
      sybb_ff <= sq16(by, pyb_ff);
      id2_ff  <= id1_ff;
      st_ff   <= min4(33'(sxa_ff) + 33'(syat_ff), 33'(sxa_ff) + 33'(sybt_ff),
                      33'(sxb_ff) + 33'(syat_ff), 33'(sxb_ff) + 33'(sybt_ff));
      sb_ff   <= min4(33'(sxa_ff) + 33'(syab_ff), 33'(sxa_ff) + 33'(sybb_ff),
                      33'(sxb_ff) + 33'(syab_ff), 33'(sxb_ff) + 33'(sybb_ff));

      // first pass keeps the smallest square; second takes the first entry
      // whose floor root matches it
      if (cmd.scan_init) begin
         first_ff <= 1'b1;
         hit_t_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else if (v2_ff) begin
         first_ff <= 1'b0;
         if (!cmd.pass2) begin
            if (first_ff || st_ff < min_t_ff) min_t_ff <= st_ff;
            if (first_ff || sb_ff < min_b_ff) min_b_ff <= sb_ff;
         end else begin
            if (!hit_t_ff && 36'(st_ff) < thr_t_ff) begin
               hit_t_ff <= 1'b1;
               id_t_ff  <= id2_ff;
            end
            if (!hit_b_ff && 36'(sb_ff) < thr_b_ff) begin
               hit_b_ff <= 1'b1;
               id_b_ff  <= id2_ff;
            end
         end
      end

      // bit-serial floor root, then the bound (r+1)^2
      if (cmd.sq_start && sq_ph_ff == SQ_IDLE) begin
         sq_sel_ff <= cmd.sq_sel;
         sq_n_ff   <= cmd.sq_sel ? min_b_ff : min_t_ff;
         sq_r_ff   <= '0;
         sq_bit_ff <= 5'd16;
      end else if (sq_ph_ff == SQ_RUN) begin
         if (sq_tt <= 34'(sq_n_ff)) sq_r_ff <= sq_t;
         sq_bit_ff <= sq_bit_ff - 5'd1;
      end else if (sq_ph_ff == SQ_FIN) begin
         if (sq_sel_ff) begin
            r_b_ff   <= sq_r_ff;
            thr_b_ff <= r_inc * r_inc;
         end else begin
            r_t_ff   <= sq_r_ff;
            thr_t_ff <= r_inc * r_inc;
         end
      end

      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign sts.full       = (count_ff == CntMax);
   assign sts.empty      = (count_ff == '0);
   assign sts.issue_done = (addr_ff == count_ff);
   assign sts.pipe_empty = !(v0_ff || v1_ff || v2_ff);
   assign sts.sq_done    = (sq_ph_ff == SQ_IDLE);
   assign rsp_data       = rsp_ff;

endmodule

FILE: rtl/nearest_segment_endpoint_search.sv
// ----------------------------------------------------------------------------
// nearest_segment_endpoint_search
// Segment table with nearest-corner search for the two ends of a span.
// ----------------------------------------------------------------------------
// Clear and add-with-room words leave busy low. An add to a full table, and a
// query of an empty table, go straight to the response state. A query of N
// stored segments walks the table twice through the table read, squares and
// nearest-corner pipeline, with two 17-step bit-serial square roots in between.
// Every result shows for one cycle on rsp_valid and cannot be held off; busy
// stays high until that cycle.
module nearest_segment_endpoint_search #(
   parameter int MAX_SEGMENTS = nsep_pkg::MAX_SEGMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nsep_pkg::req_type req_data,
   output logic              rsp_valid,
   output nsep_pkg::rsp_type rsp_data
);

   nsep_pkg::cmd_type cmd;
   nsep_pkg::sts_type sts;

   nsep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_data.action),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   nsep_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/nsep_checker.sv
// ----------------------------------------------------------------------------
// nsep_checker
// Port-level checks for the nearest segment endpoint search.
// ----------------------------------------------------------------------------
module nsep_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input nsep_pkg::req_type req_data,
   input logic              rsp_valid,
   input nsep_pkg::rsp_type rsp_data
);

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_clear_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == nsep_pkg::ACT_CLEAR |=> !busy)
      else $error("clear raised busy");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == nsep_pkg::ACT_QUERY |=> busy)
      else $error("query did not raise busy");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> !rsp_data.found)
      else $error("full word carries found");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.top_distance == '0 &&
      rsp_data.bottom_distance == '0 && rsp_data.top_nearest_id == '0)
      else $error("empty word not zero");

endmodule

bind nearest_segment_endpoint_search nsep_checker u_nsep_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, add and query words into the segment search block, keeps a
// shadow segment table, and checks every answer against a nearest-corner
// computation done here or against an expected answer given with the word.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = nsep_pkg::MAX_SEGMENTS_DEF;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      nsep_pkg::req_type w;
      bit                typed;
      nsep_pkg::rsp_type want;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   nsep_pkg::req_type req_data = '0;
   logic              rsp_valid;
   nsep_pkg::rsp_type rsp_data;

   nearest_segment_endpoint_search DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow table
   logic [15:0]        shadow_id [TABLE_DEPTH];
   logic signed [15:0] shadow_ax [TABLE_DEPTH];
   logic signed [15:0] shadow_ay [TABLE_DEPTH];
   logic signed [15:0] shadow_bx [TABLE_DEPTH];
   logic signed [15:0] shadow_by [TABLE_DEPTH];
   int                 shadow_count = 0;

   nsep_pkg::rsp_type answers_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 23;

   task automatic report_mismatch(input string what, input logic [16:0] got,
                                  input logic [16:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [16:0] floor_root(input longint unsigned n);
      logic [16:0] r;
      longint unsigned t;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
         t = longint'(r | (17'd1 << b));
         if (t * t <= n) r = r | (17'd1 << b);
      end
      return r;
   endfunction

   function automatic logic [16:0] corner_dist(input int px, input int py, input int qx,
                                               input int qy);
      longint dx, dy;
      dx = longint'(qx) - px;
      dy = longint'(qy) - py;
      return floor_root(longint'(dx * dx + dy * dy));
   endfunction

   function automatic logic [16:0] nearest_corner(input int px, input int py, input int k);
      logic [16:0] d, e;
      d = corner_dist(px, py, shadow_ax[k], shadow_ay[k]);
      e = corner_dist(px, py, shadow_ax[k], shadow_by[k]); if (e < d) d = e;
      e = corner_dist(px, py, shadow_bx[k], shadow_ay[k]); if (e < d) d = e;
      e = corner_dist(px, py, shadow_bx[k], shadow_by[k]); if (e < d) d = e;
      return d;
   endfunction

   // update the shadow table and queue any answer the word causes
   task automatic predict_answer(input nsep_pkg::req_type w, input bit typed,
                                 input nsep_pkg::rsp_type want);
      nsep_pkg::rsp_type r;
      logic [16:0] dt, db;
      bit due;
      r = '0;
      due = 1'b0;
      case (w.action)
         nsep_pkg::ACT_CLEAR: shadow_count = 0;
         nsep_pkg::ACT_ADD: begin
            if (shadow_count < TABLE_DEPTH) begin
               shadow_id[shadow_count] = w.seg_id;
               shadow_ax[shadow_count] = w.seg_ax;
               shadow_ay[shadow_count] = w.seg_ay;
               shadow_bx[shadow_count] = w.seg_bx;
               shadow_by[shadow_count] = w.seg_by;
               shadow_count++;
            end else begin
               r.table_full = 1'b1;
               due = 1'b1;
            end
         end
         nsep_pkg::ACT_QUERY: begin
            for (int k = 0; k < shadow_count; k++) begin
               dt = nearest_corner(w.span_x, w.span_top_y, k);
               db = nearest_corner(w.span_x, w.span_bottom_y, k);
               if (k == 0 || dt < r.top_distance) begin
                  r.top_distance = dt;
                  r.top_nearest_id = shadow_id[k];
               end
               if (k == 0 || db < r.bottom_distance) begin
                  r.bottom_distance = db;
                  r.bottom_nearest_id = shadow_id[k];
               end
            end
            r.found = shadow_count != 0;
            due = 1'b1;
         end
         default: ;
      endcase
      if (due) begin
         if (typed) r = want;
         answers_due = {answers_due, r};
      end
   endtask

   // check answers at the rising edge
   always @(posedge clock) begin
      nsep_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected word", 17'd0, 17'd0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", rsp_data.found, want.found);
            if (rsp_data.top_nearest_id !== want.top_nearest_id)
               report_mismatch("top_nearest_id", rsp_data.top_nearest_id,
                               want.top_nearest_id);
            if (rsp_data.top_distance !== want.top_distance)
               report_mismatch("top_distance", rsp_data.top_distance, want.top_distance);
            if (rsp_data.bottom_nearest_id !== want.bottom_nearest_id)
               report_mismatch("bottom_nearest_id", rsp_data.bottom_nearest_id,
                               want.bottom_nearest_id);
            if (rsp_data.bottom_distance !== want.bottom_distance)
               report_mismatch("bottom_distance", rsp_data.bottom_distance,
                               want.bottom_distance);
            if (rsp_data.table_full !== want.table_full)
               report_mismatch("table_full", rsp_data.table_full, want.table_full);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // hand one word over; return at the falling edge after it is accepted
   task automatic send_word(input nsep_pkg::req_type w, input bit typed,
                            input nsep_pkg::rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_answer(w, typed, want);
      @(negedge clock);
   endtask

   function automatic nsep_pkg::req_type make_word(input logic [1:0] act, input int id,
                                                   input int ax, input int ay,
                                                   input int bx, input int by,
                                                   input int sx, input int ty,
                                                   input int bty);
      nsep_pkg::req_type w;
      w.action = act; w.seg_id = 16'(id);
      w.seg_ax = 16'(ax); w.seg_ay = 16'(ay); w.seg_bx = 16'(bx); w.seg_by = 16'(by);
      w.span_x = 16'(sx); w.span_top_y = 16'(ty); w.span_bottom_y = 16'(bty);
      return w;
   endfunction

   function automatic nsep_pkg::rsp_type make_rsp(input bit found, input int tid,
                                                  input int td, input int bid,
                                                  input int bd, input bit full);
      nsep_pkg::rsp_type r;
      r.found = found;
      r.top_nearest_id = 16'(tid);
      r.top_distance = 17'(td);
      r.bottom_nearest_id = 16'(bid);
      r.bottom_distance = 17'(bd);
      r.table_full = full;
      return r;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(3))
         0: return int'($urandom_range(65535)) - 32768;
         1: return $urandom_range(1) ? 32767 : -32768;
         default: return int'($urandom_range(400)) - 200;
      endcase
   endfunction

   function automatic nsep_pkg::req_type rand_word(input logic [1:0] act);
      return make_word(act, int'($urandom_range(65535)), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord());
   endfunction

   row_type           directed_rows [14];
   nsep_pkg::rsp_type full_rsp;
   nsep_pkg::req_type w;
   int sent;

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, empty table, ties, unused action
      directed_rows = '{
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
           make_rsp(1'b0, 0, 0, 0, 0, 1'b0)},
         '{make_word(nsep_pkg::ACT_ADD, 16'hFFFF, -32768, -32768, 32767, 32767, 0, 0, 0),
           1'b0, '0},
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, -32768, -32768, 32767), 1'b1,
           make_rsp(1'b1, 16'hFFFF, 0, 16'hFFFF, 0, 1'b0)},
         '{make_word(nsep_pkg::ACT_ADD, 16'h0001, -32768, -32768, -32768, -32768, 0, 0, 0),
           1'b0, '0},
         '{make_word(nsep_pkg::ACT_ADD, 16'h0002, 32767, 32767, 32767, 32767, 0, 0, 0),
           1'b0, '0},
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 32767, -32768, 32767), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, -32768, 32767, -32768), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_UNUSED, 16'h5555, 1, 2, 3, 4, 5, 6, 7), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_ADD, 16'h00AA, 10, 10, 10, 10, 0, 0, 0), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_ADD, 16'h00BB, -10, -10, -10, -10, 0, 0, 0), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 3, 4, -7), 1'b0, '0},
         '{make_word(nsep_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0}
      };
      foreach (directed_rows[k])
         send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].want);

      // fill the table to the brim, then push adds past it
      full_rsp = make_rsp(1'b0, 0, 0, 0, 0, 1'b1);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         idle_pct = (k < 300) ? 0 : 23;
         send_word(rand_word(nsep_pkg::ACT_ADD), 1'b0, '0);
      end
      idle_pct = 23;
      for (int k = 0; k < 3; k++) send_word(rand_word(nsep_pkg::ACT_ADD), 1'b1, full_rsp);
      send_word(rand_word(nsep_pkg::ACT_QUERY), 1'b0, '0);
      send_word(rand_word(nsep_pkg::ACT_QUERY), 1'b0, '0);
      send_word(make_word(nsep_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

      // random mix on small tables
      sent = 0;
      while (sent < 540) begin
         case ($urandom_range(19))
            0: w = make_word(nsep_pkg::ACT_CLEAR, int'($urandom_range(65535)),
                             0, 0, 0, 0, 0, 0, 0);
            1:       w = rand_word(nsep_pkg::ACT_UNUSED);
            2,3,4,5,6,7,8,9,10: w = rand_word(nsep_pkg::ACT_ADD);
            default: w = rand_word(nsep_pkg::ACT_QUERY);
         endcase
         if (w.action == nsep_pkg::ACT_ADD && shadow_count > 40)
            w.action = nsep_pkg::ACT_CLEAR;
         idle_pct = (sent >= 200 && sent < 300) ? 0 : 23;
         send_word(w, 1'b0, '0);
         if (w.action != nsep_pkg::ACT_UNUSED) sent++;
      end
      start <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
